### hdl/glim_pkg.sv
// shared types and constants of the galois lfsr initialization matrix block
package glim_pkg;

   localparam int unsigned MaskWidth = 64;

   typedef logic [MaskWidth-1:0] mask_type;
   typedef logic [6:0]           count_type;
   typedef logic [5:0]           bit_index_type;
   typedef logic [7:0]           csr_index_type;

   // configuration register indexes
   localparam csr_index_type CsrTapMask   = 8'd0;
   localparam csr_index_type CsrRegLength = 8'd1;
   localparam csr_index_type CsrRowCount  = 8'd2;
   localparam csr_index_type CsrColCount  = 8'd3;

   localparam count_type MaxRounds = 7'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ROUND,
      ST_EMIT
   } state_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic clear;
      logic round;
      logic shift;
   } cell_cmd_type;

endpackage

### hdl/glim_chan_if.sv
// channel interfaces: request, response and configuration write
interface glim_req_if;
   import glim_pkg::*;
   logic          valid;
   logic          ready;
   count_type     round_count;
   bit_index_type bit_offset;

   modport source (output valid, output round_count, output bit_offset, input ready);
   modport sink   (input valid, input round_count, input bit_offset, output ready);
endinterface

interface glim_rsp_if;
   import glim_pkg::*;
   logic          valid;
   logic          ready;
   bit_index_type row_index;
   mask_type      row_bits;
   logic          last_row;

   modport source (output valid, output row_index, output row_bits, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input row_bits, input last_row,
                   output ready);
endinterface

interface glim_csr_if;
   import glim_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   mask_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/glim_cell.sv
// one register cell of the chain, holding the key-bit mask of that cell
module glim_cell (
   input  logic                  clock,
   input  glim_pkg::cell_cmd_type cmd,
   input  logic                  is_last,
   input  logic                  tap,
   input  glim_pkg::mask_type    entry,
   input  glim_pkg::mask_type    next_mask,
   output glim_pkg::mask_type    mask
);
   import glim_pkg::*;

   mask_type mask_ff;
   mask_type mask_in;

   always_comb begin
      mask_in = mask_ff;
      if (cmd.clear) begin
         mask_in = '0;
      end else if (cmd.round) begin
         if (is_last) begin
            mask_in = entry;
         end else begin
            mask_in = next_mask ^ (tap ? entry : '0);
         end
      end else if (cmd.shift) begin
         mask_in = next_mask;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
   end

   assign mask = mask_ff;

endmodule

### hdl/glim_ctrl.sv
// sequencer: offset reduction, round counting and row emission
module glim_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  glim_pkg::count_type     round_count,
   input  glim_pkg::bit_index_type bit_offset,
   input  glim_pkg::count_type     rows_eff,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output glim_pkg::bit_index_type row_index,
   output logic                    last_row,
   output glim_pkg::bit_index_type key_bit,
   output glim_pkg::cell_cmd_type  cmd
);
   import glim_pkg::*;

   state_type     state_ff, state_in;
   count_type     rounds_ff, rounds_in;
   bit_index_type key_ff, key_in;
   count_type     round_cnt_ff, round_cnt_in;
   count_type     rows_ff, rows_in;
   count_type     row_cnt_ff, row_cnt_in;

   logic      req_xfer;
   logic      rsp_xfer;
   count_type rounds_sat;
   count_type key_inc;
   count_type round_cnt_inc;
   count_type row_cnt_inc;

   assign req_xfer      = req_valid && req_ready;
   assign rsp_xfer      = rsp_valid && rsp_ready;
   assign rounds_sat    = (round_count > MaxRounds) ? MaxRounds : round_count;
   assign key_inc       = {1'b0, key_ff} + 7'd1;
   assign round_cnt_inc = round_cnt_ff + 7'd1;
   assign row_cnt_inc   = row_cnt_ff + 7'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rounds_ff    <= '0;
         key_ff       <= '0;
         round_cnt_ff <= '0;
         rows_ff      <= '0;
         row_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rounds_ff    <= rounds_in;
         key_ff       <= key_in;
         round_cnt_ff <= round_cnt_in;
         rows_ff      <= rows_in;
         row_cnt_ff   <= row_cnt_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rounds_in    = rounds_ff;
      key_in       = key_ff;
      round_cnt_in = round_cnt_ff;
      rows_in      = rows_ff;
      row_cnt_in   = row_cnt_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.clear    = 1'b1;
               rounds_in    = rounds_sat;
               key_in       = bit_offset;
               round_cnt_in = '0;
               rows_in      = rows_eff;
               row_cnt_in   = '0;
               if (rounds_sat != '0) begin
                  state_in = ST_REDUCE;
               end else if (rows_eff != '0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_REDUCE: begin
            // offset mod rounds by repeated subtraction
            if ({1'b0, key_ff} >= rounds_ff) begin
               key_in = key_ff - rounds_ff[5:0];
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round    = 1'b1;
            key_in       = (key_inc == rounds_ff) ? '0 : key_inc[5:0];
            round_cnt_in = round_cnt_inc;
            if (round_cnt_inc == rounds_ff) begin
               state_in = (rows_ff != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift  = 1'b1;
               row_cnt_in = row_cnt_inc;
               if (row_cnt_inc == rows_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign row_index = row_cnt_ff[5:0];
   assign last_row  = (row_cnt_inc == rows_ff);
   assign key_bit   = key_ff;

`ifndef NO_ASSERTIONS
   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (row_cnt_ff < rows_ff))
      else $error("row counter beyond row count");

   a_key_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> ({1'b0, key_ff} < rounds_ff))
      else $error("key bit index not reduced below round count");

   a_reduce_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE) |-> (rounds_ff != '0))
      else $error("offset reduction with zero rounds");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && last_row) |=> (state_ff == ST_IDLE))
      else $error("request not finished after last row");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> (!cmd.round && !cmd.shift))
      else $error("clear overlaps a round or shift");
`endif

endmodule

### hdl/galois_lfsr_init_matrix.sv
// top level: configuration registers, chain of mask cells and sequencer
//
//  channel  | dir | transfer when            | payload
//  ---------+-----+--------------------------+----------------------------------
//  req_chan | in  | valid && ready           | round_count, bit_offset
//  rsp_chan | out | valid && ready           | row_index, row_bits, last_row
//  csr_chan | in  | valid && ready (ready=1) | index, data
//
//  a request goes through these steps in order: the accepting cycle clears the
//  chain, the offset is reduced mod rounds by repeated subtraction, the rounds run
//  and the rows are shifted out of cell 0; zero rounds skips reduction and rounds.
//  one round per cycle
//  reset is synchronous, active high; the chain holds no reset, it is
//  cleared by the request that takes it
//  a stalled response holds the chain, the row stays in cell 0
module galois_lfsr_init_matrix #(
   parameter int unsigned MAX_CELLS = 64
) (
   input logic       clock,
   input logic       reset,
   glim_req_if.sink   req_chan,
   glim_rsp_if.source rsp_chan,
   glim_csr_if.sink   csr_chan
);
   import glim_pkg::*;

   localparam count_type MaxLen = 7'(MAX_CELLS);

   // configuration registers
   mask_type  tap_mask_ff;
   count_type reg_length_ff;
   count_type row_count_ff;
   count_type col_count_ff;

   count_type    len_eff;
   count_type    rows_eff;
   mask_type     col_mask;
   mask_type     entry;
   bit_index_type key_bit;
   cell_cmd_type cmd;

   mask_type cell_mask [MAX_CELLS];

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_mask_ff   <= '0;
         reg_length_ff <= 7'd64;
         row_count_ff  <= 7'd64;
         col_count_ff  <= 7'd64;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CsrTapMask:   tap_mask_ff   <= csr_chan.data;
            CsrRegLength: reg_length_ff <= csr_chan.data[6:0];
            CsrRowCount:  row_count_ff  <= csr_chan.data[6:0];
            CsrColCount:  col_count_ff  <= csr_chan.data[6:0];
            default: ; // writes past the register list are dropped
         endcase
      end
   end

   // effective length, clamped to one..MAX_CELLS
   always_comb begin
      if (reg_length_ff == '0) begin
         len_eff = 7'd1;
      end else if (reg_length_ff > MaxLen) begin
         len_eff = MaxLen;
      end else begin
         len_eff = reg_length_ff;
      end
   end

   assign rows_eff = (row_count_ff > len_eff) ? len_eff : row_count_ff;

   // low col_count bits kept; zero keeps none
   assign col_mask = (col_count_ff >= 7'd64) ? '1 : ~({MaskWidth{1'b1}} << col_count_ff[5:0]);

   // feedback word of the current round
   assign entry = cell_mask[0] ^ (mask_type'(1) << key_bit);

   genvar j;
   generate
      for (j = 0; j < MAX_CELLS; j++) begin : g_cell
         mask_type next_mask;
         if (j == MAX_CELLS - 1) begin : g_end
            assign next_mask = '0;
         end else begin : g_mid
            assign next_mask = cell_mask[j+1];
         end

         glim_cell u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .is_last   (len_eff == 7'(j + 1)),
            .tap       (tap_mask_ff[j]),
            .entry     (entry),
            .next_mask (next_mask),
            .mask      (cell_mask[j])
         );
      end
   endgenerate

   glim_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .round_count (req_chan.round_count),
      .bit_offset  (req_chan.bit_offset),
      .rows_eff    (rows_eff),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .row_index   (rsp_chan.row_index),
      .last_row    (rsp_chan.last_row),
      .key_bit     (key_bit),
      .cmd         (cmd)
   );

   // rows leave through cell 0 as the chain shifts down
   assign rsp_chan.row_bits = cell_mask[0] & col_mask;

endmodule
